// ===== sv/tret_pkg.sv =====
// shared constants, codes and types of the transfer ring enqueue tracker
package tret_pkg;

    localparam int SLOT_W      = 8;
    localparam int RING_DEPTH  = 1 << SLOT_W;
    localparam int TAG_W       = 6;
    localparam int TAG_COUNT   = 1 << TAG_W;
    localparam int CNT_W       = 5;
    localparam int MAX_TRBS    = 16;
    localparam int RS_W        = 9;
    localparam int STATUS_W    = 3;
    localparam int REQ_W       = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_RESET   = 2'd2
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED     = 3'd0,
        ST_FULL       = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_RESET_DONE = 3'd4
    } status_t;

    // first slot and slot count of one request
    typedef struct packed {
        logic [SLOT_W-1:0] first;
        logic [CNT_W-1:0]  count;
    } rec_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic [SLOT_W-1:0] chk_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [TAG_W-1:0]  wr_tag;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_addr;
        logic              clr_all;
    } owner_cmd_t;

    typedef struct packed {
        logic             rd_en;
        logic [TAG_W-1:0] rd_addr;
        logic             wr_en;
        logic [TAG_W-1:0] wr_addr;
        rec_t             wr_data;
    } rec_cmd_t;

endpackage

// ===== sv/tret_if.sv =====
// request and result channel interfaces of the transfer ring enqueue tracker
interface tret_req_if;
    logic                          valid;
    logic                          ready;
    logic [tret_pkg::REQ_W-1:0]    req_type;
    logic [tret_pkg::CNT_W-1:0]    trb_count;
    logic [tret_pkg::TAG_W-1:0]    request_tag;
    logic [tret_pkg::SLOT_W-1:0]   release_position;

    modport source (
        output valid, req_type, trb_count, request_tag, release_position,
        input  ready
    );
    modport sink (
        input  valid, req_type, trb_count, request_tag, release_position,
        output ready
    );
endinterface

interface tret_res_if;
    logic                          valid;
    logic                          ready;
    logic [tret_pkg::STATUS_W-1:0] status;
    logic [tret_pkg::SLOT_W-1:0]   slot_position;
    logic                          slot_cycle;
    logic                          slot_is_link;
    logic [tret_pkg::TAG_W-1:0]    owner_tag;
    logic                          last;

    modport source (
        output valid, status, slot_position, slot_cycle, slot_is_link, owner_tag, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot_position, slot_cycle, slot_is_link, owner_tag, last,
        output ready
    );
endinterface

// ===== sv/transfer_ring_enqueue_tracker_unit.sv =====
// top level of the transfer ring enqueue tracker: sequencer, config and result register
// insert of n slots: accept, a scan of the n slots (and the link if passed) over the valid
// flops, then an emit of n results (+1 link), one per cycle while the output register is free;
// release: owner check, record read, walk of the recorded slots, result; ring reset and bad
// count give a lone result, as does an empty slot; a new request is taken only when idle
// async reset: all slots free at once (valid flops), enqueue position 0, cycle bit 1,
// ring_slots 256, no clearing pass; the request record memory is not cleared
module transfer_ring_enqueue_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tret_pkg::RS_W-1:0]     cfg_wr_data,
    tret_req_if.sink                      req,
    tret_res_if.source                    res
);

    typedef struct packed {
        tret_pkg::status_t              status;
        logic [tret_pkg::SLOT_W-1:0]    slot_position;
        logic                           slot_cycle;
        logic                           slot_is_link;
        logic [tret_pkg::TAG_W-1:0]     owner_tag;
        logic                           last;
    } res_t;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_EMIT     = 8'b0000_0100,
        S_REL_OWN  = 8'b0000_1000,
        S_REL_REC  = 8'b0001_0000,
        S_REL_WALK = 8'b0010_0000,
        S_REL_DONE = 8'b0100_0000,
        S_SINGLE   = 8'b1000_0000
    } state_t;

    function automatic res_t mk_res(
        tret_pkg::status_t              st,
        logic [tret_pkg::SLOT_W-1:0]    pos,
        logic                           cyc,
        logic                           lnk,
        logic [tret_pkg::TAG_W-1:0]     tag,
        logic                           lst
    );
        res_t r;
        r.status        = st;
        r.slot_position = pos;
        r.slot_cycle    = cyc;
        r.slot_is_link  = lnk;
        r.owner_tag     = tag;
        r.last          = lst;
        return r;
    endfunction

    localparam logic [tret_pkg::SLOT_W-1:0] SLOT_ZERO = '0;
    localparam logic [tret_pkg::TAG_W-1:0]  TAG_ZERO  = '0;

    // control state
    state_t                         state_reg, state_next;
    logic [tret_pkg::RS_W-1:0]      ring_slots_reg, ring_slots_next;
    logic [tret_pkg::SLOT_W-1:0]    enq_pos_reg, enq_pos_next;
    logic                           prod_cyc_reg, prod_cyc_next;
    logic                           out_valid_reg, out_valid_next;

    // working registers of the item in flight
    logic [tret_pkg::SLOT_W-1:0]    scan_pos_reg, scan_pos_next;
    logic                           scan_cyc_reg, scan_cyc_next;
    logic [tret_pkg::CNT_W-1:0]     placed_reg, placed_next;
    logic [tret_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [tret_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic [tret_pkg::SLOT_W-1:0]    rpos_reg, rpos_next;
    logic [tret_pkg::SLOT_W-1:0]    walk_addr_reg, walk_addr_next;
    logic [tret_pkg::CNT_W-1:0]     walk_rem_reg, walk_rem_next;
    res_t                           single_res_reg, single_res_next;
    res_t                           out_res_reg, out_res_next;

    // store interfaces
    tret_pkg::owner_cmd_t           owner_cmd;
    logic [tret_pkg::TAG_W-1:0]     owner_rd_tag;
    logic                           owner_chk_valid;
    tret_pkg::rec_cmd_t             rec_cmd;
    tret_pkg::rec_t                 rec_rd_data;

    // derived values
    logic [tret_pkg::RS_W-1:0]      eff_slots;
    logic [tret_pkg::SLOT_W-1:0]    link_pos;
    logic                           out_free;
    logic                           bad_count;
    logic [tret_pkg::CNT_W-1:0]     placed_inc;
    logic                           place_last;
    logic [tret_pkg::SLOT_W-1:0]    scan_pos_inc;
    logic [tret_pkg::SLOT_W-1:0]    rec_first;
    logic [tret_pkg::SLOT_W-1:0]    walk_inc;
    logic [tret_pkg::SLOT_W-1:0]    walk_nxt;

    tret_owner_store u_owner (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (owner_cmd),
        .rd_tag    (owner_rd_tag),
        .chk_valid (owner_chk_valid)
    );

    tret_record_store u_record (
        .clk     (clk),
        .cmd     (rec_cmd),
        .rd_data (rec_rd_data)
    );

    // ring size clamped to 2..RING_DEPTH, link is the last slot
    always_comb
    begin
        if (ring_slots_reg < tret_pkg::RS_W'(2))
        begin
            eff_slots = tret_pkg::RS_W'(2);
        end
        else if (ring_slots_reg > tret_pkg::RS_W'(tret_pkg::RING_DEPTH))
        begin
            eff_slots = tret_pkg::RS_W'(tret_pkg::RING_DEPTH);
        end
        else
        begin
            eff_slots = ring_slots_reg;
        end
    end

    assign link_pos = tret_pkg::SLOT_W'(eff_slots - tret_pkg::RS_W'(1));

    // a count of zero, too many trbs or more than the usable ring is answered as full
    assign bad_count = (req.trb_count == '0)
                    || ({1'b0, req.trb_count} > (tret_pkg::CNT_W + 1)'(tret_pkg::MAX_TRBS))
                    || (tret_pkg::SLOT_W'(req.trb_count) > link_pos);

    assign out_free     = !out_valid_reg || res.ready;
    assign placed_inc   = placed_reg + tret_pkg::CNT_W'(1);
    assign place_last   = (placed_inc == count_reg);
    assign scan_pos_inc = scan_pos_reg + tret_pkg::SLOT_W'(1);

    // release walk wraps at the current link
    assign rec_first = (rec_rd_data.first >= link_pos) ? SLOT_ZERO : rec_rd_data.first;
    assign walk_inc  = walk_addr_reg + tret_pkg::SLOT_W'(1);
    assign walk_nxt  = (walk_inc >= link_pos) ? SLOT_ZERO : walk_inc;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        enq_pos_next    = enq_pos_reg;
        prod_cyc_next   = prod_cyc_reg;
        scan_pos_next   = scan_pos_reg;
        scan_cyc_next   = scan_cyc_reg;
        placed_next     = placed_reg;
        count_next      = count_reg;
        tag_next        = tag_reg;
        rpos_next       = rpos_reg;
        walk_addr_next  = walk_addr_reg;
        walk_rem_next   = walk_rem_reg;
        single_res_next = single_res_reg;
        out_res_next    = out_res_reg;
        owner_cmd       = '0;
        rec_cmd         = '0;
        ring_slots_next = cfg_wr_en ? cfg_wr_data : ring_slots_reg;
        out_valid_next  = out_valid_reg && !res.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        tret_pkg::REQ_INSERT:
                        begin
                            count_next    = req.trb_count;
                            tag_next      = req.request_tag;
                            scan_pos_next = enq_pos_reg;
                            scan_cyc_next = prod_cyc_reg;
                            placed_next   = '0;
                            if (bad_count)
                            begin
                                single_res_next = mk_res(tret_pkg::ST_FULL, SLOT_ZERO, 1'b0,
                                                         1'b0, req.request_tag, 1'b1);
                                state_next      = S_SINGLE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        tret_pkg::REQ_RELEASE:
                        begin
                            rpos_next         = req.release_position;
                            owner_cmd.rd_en   = 1'b1;
                            owner_cmd.rd_addr = req.release_position;
                            state_next        = S_REL_OWN;
                        end
                        tret_pkg::REQ_RESET:
                        begin
                            owner_cmd.clr_all = 1'b1;
                            enq_pos_next      = '0;
                            prod_cyc_next     = 1'b1;
                            single_res_next   = mk_res(tret_pkg::ST_RESET_DONE, SLOT_ZERO,
                                                       1'b0, 1'b0, TAG_ZERO, 1'b1);
                            state_next        = S_SINGLE;
                        end
                        default:
                        begin
                            // unused request type, no result
                        end
                    endcase
                end
            end

            // check one slot per cycle, stepping over the link
            S_SCAN:
            begin
                owner_cmd.chk_addr = scan_pos_reg;
                if (scan_pos_reg >= link_pos)
                begin
                    scan_pos_next = '0;
                    scan_cyc_next = !scan_cyc_reg;
                end
                else if (owner_chk_valid)
                begin
                    single_res_next = mk_res(tret_pkg::ST_FULL, SLOT_ZERO, 1'b0, 1'b0,
                                             tag_reg, 1'b1);
                    state_next      = S_SINGLE;
                end
                else if (place_last)
                begin
                    // all free: replay the same path and commit
                    scan_pos_next = enq_pos_reg;
                    scan_cyc_next = prod_cyc_reg;
                    placed_next   = '0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    placed_next   = placed_inc;
                    scan_pos_next = scan_pos_inc;
                end
            end

            // one placed item per cycle while the output register is free, owner and record written on the way
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (scan_pos_reg >= link_pos)
                    begin
                        out_res_next  = mk_res(tret_pkg::ST_PLACED, scan_pos_reg, scan_cyc_reg,
                                               1'b1, tag_reg, 1'b0);
                        scan_pos_next = '0;
                        scan_cyc_next = !scan_cyc_reg;
                    end
                    else
                    begin
                        out_res_next      = mk_res(tret_pkg::ST_PLACED, scan_pos_reg,
                                                   scan_cyc_reg, 1'b0, tag_reg, place_last);
                        owner_cmd.wr_en   = 1'b1;
                        owner_cmd.wr_addr = scan_pos_reg;
                        owner_cmd.wr_tag  = tag_reg;
                        if (placed_reg == '0)
                        begin
                            rec_cmd.wr_en         = 1'b1;
                            rec_cmd.wr_addr       = tag_reg;
                            rec_cmd.wr_data.first = scan_pos_reg;
                            rec_cmd.wr_data.count = count_reg;
                        end
                        placed_next   = placed_inc;
                        scan_pos_next = scan_pos_inc;
                        if (place_last)
                        begin
                            enq_pos_next  = scan_pos_inc;
                            prod_cyc_next = scan_cyc_reg;
                            state_next    = S_IDLE;
                        end
                    end
                end
            end

            // owner of the named slot is back
            S_REL_OWN:
            begin
                owner_cmd.chk_addr = rpos_reg;
                if (!owner_chk_valid)
                begin
                    single_res_next = mk_res(tret_pkg::ST_EMPTY, rpos_reg, 1'b0, 1'b0,
                                             TAG_ZERO, 1'b1);
                    state_next      = S_SINGLE;
                end
                else
                begin
                    tag_next        = owner_rd_tag;
                    rec_cmd.rd_en   = 1'b1;
                    rec_cmd.rd_addr = owner_rd_tag;
                    state_next      = S_REL_REC;
                end
            end

            S_REL_REC:
            begin
                walk_rem_next = rec_rd_data.count;
                if (rec_rd_data.count == '0)
                begin
                    state_next = S_REL_DONE;
                end
                else
                begin
                    owner_cmd.rd_en   = 1'b1;
                    owner_cmd.rd_addr = rec_first;
                    walk_addr_next    = rec_first;
                    state_next        = S_REL_WALK;
                end
            end

            // one slot per cycle; the valid flops already carry earlier frees
            S_REL_WALK:
            begin
                owner_cmd.chk_addr = walk_addr_reg;
                if (owner_chk_valid && (owner_rd_tag == tag_reg))
                begin
                    owner_cmd.clr_en   = 1'b1;
                    owner_cmd.clr_addr = walk_addr_reg;
                end
                walk_rem_next = walk_rem_reg - tret_pkg::CNT_W'(1);
                if (walk_rem_reg == tret_pkg::CNT_W'(1))
                begin
                    state_next = S_REL_DONE;
                end
                else
                begin
                    owner_cmd.rd_en   = 1'b1;
                    owner_cmd.rd_addr = walk_nxt;
                    walk_addr_next    = walk_nxt;
                end
            end

            S_REL_DONE:
            begin
                owner_cmd.clr_en   = 1'b1;
                owner_cmd.clr_addr = rpos_reg;
                single_res_next    = mk_res(tret_pkg::ST_RELEASED, rpos_reg, 1'b0, 1'b0,
                                            tag_reg, 1'b1);
                state_next         = S_SINGLE;
            end

            // lone result waits for the output register
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = single_res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ring_slots_reg <= tret_pkg::RS_W'(tret_pkg::RING_DEPTH);
            enq_pos_reg    <= '0;
            prod_cyc_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ring_slots_reg <= ring_slots_next;
            enq_pos_reg    <= enq_pos_next;
            prod_cyc_reg   <= prod_cyc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pos_reg   <= scan_pos_next;
        scan_cyc_reg   <= scan_cyc_next;
        placed_reg     <= placed_next;
        count_reg      <= count_next;
        tag_reg        <= tag_next;
        rpos_reg       <= rpos_next;
        walk_addr_reg  <= walk_addr_next;
        walk_rem_reg   <= walk_rem_next;
        single_res_reg <= single_res_next;
        out_res_reg    <= out_res_next;
    end

    // output register drives the result channel
    assign res.valid         = out_valid_reg;
    assign res.status        = out_res_reg.status;
    assign res.slot_position = out_res_reg.slot_position;
    assign res.slot_cycle    = out_res_reg.slot_cycle;
    assign res.slot_is_link  = out_res_reg.slot_is_link;
    assign res.owner_tag     = out_res_reg.owner_tag;
    assign res.last          = out_res_reg.last;

endmodule

// ===== sv/tret_owner_store.sv =====
// slot owner store: tag memory plus one valid flop per slot
module tret_owner_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tret_pkg::owner_cmd_t         cmd,
    output logic [tret_pkg::TAG_W-1:0]   rd_tag,
    output logic                         chk_valid
);

    logic [tret_pkg::TAG_W-1:0]      tag_mem [tret_pkg::RING_DEPTH];
    logic [tret_pkg::TAG_W-1:0]      rd_tag_reg;
    logic [tret_pkg::RING_DEPTH-1:0] valid_reg;
    logic [tret_pkg::RING_DEPTH-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            tag_mem[cmd.wr_addr] <= cmd.wr_tag;
        end
        if (cmd.rd_en)
        begin
            rd_tag_reg <= tag_mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clr_all)
        begin
            valid_next = '0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_next[cmd.wr_addr] = 1'b1;
            end
            if (cmd.clr_en)
            begin
                valid_next[cmd.clr_addr] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_tag    = rd_tag_reg;
    assign chk_valid = valid_reg[cmd.chk_addr];

endmodule

// ===== sv/tret_record_store.sv =====
// request record memory: first slot and count per tag
module tret_record_store (
    input  logic               clk,
    input  tret_pkg::rec_cmd_t cmd,
    output tret_pkg::rec_t     rd_data
);

    tret_pkg::rec_t rec_mem [tret_pkg::TAG_COUNT];
    tret_pkg::rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            rec_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= rec_mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
